// ----- sv/mlpe_pkg.sv -----
package mlpe_pkg;

   localparam int NUM_IN    = 8;   // input values carried by every word
   localparam int IN_W      = 16;  // Q1.15 input
   localparam int COEF_W    = 18;  // Q3.15 coefficient
   localparam int PROD_W    = 17;  // subset product, -1.0 .. +1.0 inclusive
   localparam int M1_W      = PROD_W + IN_W;
   localparam int M2_W      = COEF_W + PROD_W;
   localparam int FRAC_BITS = 15;
   localparam int TERM_W    = M2_W - FRAC_BITS;
   localparam int ACC_W     = 27;  // 256 terms of at most 2^17 each, plus margin
   localparam int SUM_W     = 26;
   localparam int SEL_W     = 3;   // picks one of NUM_IN inputs
   localparam int CFG_W     = 4;
   localparam int CIDX_W    = 8;   // width of the coeff_index field

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_EVAL = 1'b1;

   // 1.0 in Q1.15, already shifted up by FRAC_BITS, for the empty subset
   localparam logic signed [M1_W-1:0] M1_UNITY = 33'sh0_4000_0000;
   localparam logic signed [PROD_W-1:0] PROD_ONE = 17'sh0_8000;

   localparam logic signed [ACC_W-1:0] SUM_MAX = 27'sd33554431;
   localparam logic signed [ACC_W-1:0] SUM_MIN = -27'sd33554432;

   typedef logic signed [IN_W-1:0] in_val_type;

   typedef struct packed {
      logic issue;  // index on the bus is valid this cycle
      logic last;   // final index of the evaluation
   } issue_ctl_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ISSUE = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_OUT   = 4'b1000
   } state_type;

endpackage

// ----- sv/mlpe_coef_store.sv -----
module mlpe_coef_store import mlpe_pkg::*; #(
   parameter int IDX_W = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [IDX_W-1:0]         wr_addr,
   input  logic signed [COEF_W-1:0] wr_data,
   input  logic                     rd_en,
   input  logic [IDX_W-1:0]         rd_addr,
   output logic signed [COEF_W-1:0] rd_data
);

   localparam int DEPTH = 1 << IDX_W;

   logic signed [COEF_W-1:0] mem [DEPTH];
   logic signed [COEF_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/mlpe_term_pipe.sv -----
module mlpe_term_pipe import mlpe_pkg::*; #(
   parameter int IDX_W = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  issue_ctl_type            ctl,
   input  logic [IDX_W-1:0]         idx,
   input  in_val_type               x [NUM_IN],
   input  logic signed [COEF_W-1:0] coef_rd,
   output logic                     done,
   output logic signed [SUM_W-1:0]  poly_sum
);

   localparam int DEPTH = 1 << IDX_W;

   // subset products, entry i = product over the set bits of i
   logic signed [PROD_W-1:0] prod_mem [DEPTH];

   // issue decode: top set bit selects the input, the rest is the parent subset
   logic [SEL_W-1:0] msb_pos;
   logic [IDX_W-1:0] msb_mask;
   logic [IDX_W-1:0] parent;

   always_comb begin
      msb_pos  = '0;
      msb_mask = '0;
      for (int b = 0; b < IDX_W; b++) begin
         if (idx[b]) begin
            msb_pos  = SEL_W'(b);
            msb_mask = IDX_W'(1) << b;
         end
      end
      parent = idx & ~msb_mask;
   end

   // stage A: memory read in flight
   logic                     a_valid_ff, a_valid_in;
   logic                     a_last_ff;
   logic                     a_first_ff;
   logic                     a_pzero_ff;
   logic [IDX_W-1:0]         a_parent_ff;
   logic [IDX_W-1:0]         a_idx_ff;
   logic signed [IN_W-1:0]   a_x_ff;
   logic signed [PROD_W-1:0] a_prod_rd_ff;

   // stage B: parent times input
   logic                     b_valid_ff;
   logic                     b_last_ff;
   logic                     b_first_ff;
   logic [IDX_W-1:0]         b_idx_ff;
   logic signed [M1_W-1:0]   b_m1_ff, b_m1_in;
   logic signed [COEF_W-1:0] b_coef_ff;
   logic signed [PROD_W-1:0] b_parent_prod;

   // stage C: coefficient times subset product
   logic                     c_valid_ff;
   logic                     c_last_ff;
   logic                     c_first_ff;
   logic signed [M2_W-1:0]   c_m2_ff, c_m2_in;
   logic signed [PROD_W-1:0] c_prod;

   // write-through copy for a read that lands on the edge of its own write
   logic                     fwd_valid_ff;
   logic [IDX_W-1:0]         fwd_idx_ff;
   logic signed [PROD_W-1:0] fwd_val_ff;

   // stage D: accumulate
   logic                     done_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [TERM_W-1:0] term;

   assign a_valid_in = ctl.issue;

   always_comb begin
      if (a_pzero_ff) begin
         b_parent_prod = PROD_ONE;
      end else if (fwd_valid_ff && (fwd_idx_ff == a_parent_ff)) begin
         b_parent_prod = fwd_val_ff;
      end else begin
         b_parent_prod = a_prod_rd_ff;
      end
      if (a_first_ff) begin
         b_m1_in = M1_UNITY;
      end else begin
         b_m1_in = M1_W'(b_parent_prod) * M1_W'(a_x_ff);
      end
   end

   assign c_prod  = b_m1_ff[FRAC_BITS +: PROD_W];
   assign c_m2_in = M2_W'(b_coef_ff) * M2_W'(c_prod);

   assign term = c_m2_ff[M2_W-1:FRAC_BITS];

   always_comb begin
      if (c_first_ff) begin
         acc_in = ACC_W'(term);
      end else begin
         acc_in = acc_ff + ACC_W'(term);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         fwd_valid_ff <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= a_valid_ff;
         c_valid_ff   <= b_valid_ff;
         fwd_valid_ff <= b_valid_ff;
         done_ff      <= c_valid_ff && c_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.issue) begin
         a_prod_rd_ff <= prod_mem[parent];
      end
      if (b_valid_ff) begin
         prod_mem[b_idx_ff] <= c_prod;
      end
      a_last_ff   <= ctl.last;
      a_first_ff  <= (idx == '0);
      a_pzero_ff  <= (parent == '0);
      a_parent_ff <= parent;
      a_idx_ff    <= idx;
      a_x_ff      <= x[msb_pos];

      b_last_ff   <= a_last_ff;
      b_first_ff  <= a_first_ff;
      b_idx_ff    <= a_idx_ff;
      b_m1_ff     <= b_m1_in;
      b_coef_ff   <= coef_rd;

      c_last_ff   <= b_last_ff;
      c_first_ff  <= b_first_ff;
      c_m2_ff     <= c_m2_in;

      fwd_idx_ff  <= b_idx_ff;
      fwd_val_ff  <= c_prod;

      if (c_valid_ff) begin
         acc_ff <= acc_in;
      end
   end

   always_comb begin
      if (acc_ff > SUM_MAX) begin
         poly_sum = SUM_MAX[SUM_W-1:0];
      end else if (acc_ff < SUM_MIN) begin
         poly_sum = SUM_MIN[SUM_W-1:0];
      end else begin
         poly_sum = acc_ff[SUM_W-1:0];
      end
   end

   assign done = done_ff;

endmodule

// ----- sv/multilinear_poly_eval_unit.sv -----
// channel   | handshake            | payload
// ----------+----------------------+---------------------------------------------
// req       | req_valid/req_stall  | mode, coeff_index, coeff_value, in_value_0..7
// rsp       | rsp_valid/rsp_stall  | poly_sum (one word per evaluate request)
// csr       | csr_wr_en            | active_inputs, to be written only while idle (user rule, unenforced)
//
// A load word writes one coefficient.
// An evaluate word reads the coefficient store once per cycle, for indices 0 to
// 2^n - 1 (n = active inputs, capped at MAX_INPUTS), then registers its result.
// Reset is synchronous; it clears control state only, coefficients stay undefined.
// A stalled result stays in the output register; req is stalled only while an
// evaluation is running or waiting for that register.
module multilinear_poly_eval_unit import mlpe_pkg::*; #(
   parameter int MAX_INPUTS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_mode,
   input  logic [CIDX_W-1:0]        req_coeff_index,
   input  logic signed [COEF_W-1:0] req_coeff_value,
   input  logic signed [IN_W-1:0]   req_in_value_0,
   input  logic signed [IN_W-1:0]   req_in_value_1,
   input  logic signed [IN_W-1:0]   req_in_value_2,
   input  logic signed [IN_W-1:0]   req_in_value_3,
   input  logic signed [IN_W-1:0]   req_in_value_4,
   input  logic signed [IN_W-1:0]   req_in_value_5,
   input  logic signed [IN_W-1:0]   req_in_value_6,
   input  logic signed [IN_W-1:0]   req_in_value_7,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [SUM_W-1:0]  rsp_poly_sum,
   input  logic                     csr_wr_en,
   input  logic [CFG_W-1:0]         csr_wr_data
);

   localparam int IDX_W = MAX_INPUTS;
   localparam int CNT_W = IDX_W + 1;

   state_type state_ff, state_in;

   logic [CFG_W-1:0]  active_ff;
   logic [CFG_W-1:0]  n_eff;
   logic [CNT_W-1:0]  span;
   logic [CNT_W-1:0]  span_m1;
   logic [IDX_W-1:0]  last_ff, last_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;

   in_val_type req_vals [NUM_IN];
   in_val_type x_ff [NUM_IN];

   logic req_acc;
   logic eval_acc;
   logic load_acc;
   logic rsp_free;
   logic rsp_load;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [SUM_W-1:0] rsp_sum_ff;

   issue_ctl_type           ctl;
   logic signed [COEF_W-1:0] coef_rd;
   logic                    pipe_done;
   logic signed [SUM_W-1:0] pipe_sum;

   assign req_vals[0] = req_in_value_0;
   assign req_vals[1] = req_in_value_1;
   assign req_vals[2] = req_in_value_2;
   assign req_vals[3] = req_in_value_3;
   assign req_vals[4] = req_in_value_4;
   assign req_vals[5] = req_in_value_5;
   assign req_vals[6] = req_in_value_6;
   assign req_vals[7] = req_in_value_7;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign eval_acc  = req_acc && (req_mode == MODE_EVAL);
   assign load_acc  = req_acc && (req_mode == MODE_LOAD);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // last index = 2^n - 1, n capped at the store size
   assign n_eff   = (active_ff > CFG_W'(MAX_INPUTS)) ? CFG_W'(MAX_INPUTS) : active_ff;
   assign span    = CNT_W'(1) << n_eff;
   assign span_m1 = span - CNT_W'(1);
   assign last_in = span_m1[IDX_W-1:0];

   assign ctl.issue = (state_ff == ST_ISSUE);
   assign ctl.last  = (idx_ff == last_ff);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      rsp_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (eval_acc) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            idx_in = idx_ff + IDX_W'(1);
            if (ctl.last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (pipe_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         active_ff    <= CFG_W'(MAX_INPUTS);
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            active_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (eval_acc) begin
         last_ff <= last_in;
         for (int j = 0; j < NUM_IN; j++) begin
            x_ff[j] <= req_vals[j];
         end
      end
      if (rsp_load) begin
         rsp_sum_ff <= pipe_sum;
      end
   end

   mlpe_coef_store #(
      .IDX_W (IDX_W)
   ) u_coef_store (
      .clock   (clock),
      .wr_en   (load_acc),
      .wr_addr (req_coeff_index[IDX_W-1:0]),
      .wr_data (req_coeff_value),
      .rd_en   (ctl.issue),
      .rd_addr (idx_ff),
      .rd_data (coef_rd)
   );

   mlpe_term_pipe #(
      .IDX_W (IDX_W)
   ) u_term_pipe (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .idx      (idx_ff),
      .x        (x_ff),
      .coef_rd  (coef_rd),
      .done     (pipe_done),
      .poly_sum (pipe_sum)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_poly_sum = rsp_sum_ff;

endmodule

// ----- sv/mlpe_checker.sv -----
module mlpe_checker import mlpe_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic                    req_mode,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic signed [SUM_W-1:0] rsp_poly_sum
);

   // result word held while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_poly_sum))
      else $error("rsp word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // an evaluation keeps the request side busy
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_mode == MODE_EVAL) |=> req_stall)
      else $error("request taken during evaluation");

   // a coefficient load never produces a result word
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_mode == MODE_LOAD) && !rsp_valid |=> !rsp_valid)
      else $error("result word after a load");

endmodule

bind multilinear_poly_eval_unit mlpe_checker u_mlpe_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .req_mode     (req_mode),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_poly_sum (rsp_poly_sum)
);
